[hdl/stt_pkg.sv]
// Shared types and constants for the software timer table.
// No dependencies.
`timescale 1ns / 1ps
package stt_pkg;
  localparam int NumTimers = 16;
  localparam int SlotW = 4;
  localparam int MaxFires = 64;
  localparam int FireCntW = 7;

  typedef enum logic [2:0] {
    MODE_TICK = 3'd0, MODE_ARM_ONE = 3'd1, MODE_ARM_PER = 3'd2, MODE_CHANGE = 3'd3,
    MODE_PAUSE = 3'd4, MODE_RESUME = 3'd5, MODE_CANCEL = 3'd6, MODE_NONE = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0, KIND_ARMED = 2'd1, KIND_FULL = 2'd2, KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TIME, ST_SCAN, ST_FIRE, ST_OP, ST_OUT, ST_LAST
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic adv_time;  // advance clock on tick
    logic scan_clr;  // restart scan from slot 0
    logic scan_step; // examine current slot
    logic fire;      // fire found slot, hold it, send the previous held one
    logic emit_last; // send the held fire beat as last
    logic do_op;     // execute non-tick request, queue reply
    logic out_pop;   // result taken
  } stt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic is_none;
    logic hit;       // current scan slot due
    logic scan_end;  // current scan slot is last
    logic fires_max; // fire budget spent
    logic held;      // a fire beat waits in the hold register
    logic out_full;
  } stt_sts_t;
endpackage

[hdl/stt_ctrl.sv]
// Controller state machine for the timer table.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  stt_pkg::stt_sts_t sts,
  output stt_pkg::stt_cmd_t cmd
);
  stt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= stt_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::ST_IDLE: if (in_valid) state_nxt = stt_pkg::ST_TIME;
      stt_pkg::ST_TIME: begin
        if (sts.is_none) state_nxt = stt_pkg::ST_IDLE;
        else if (sts.is_tick) state_nxt = stt_pkg::ST_SCAN;
        else state_nxt = stt_pkg::ST_OP;
      end
      stt_pkg::ST_SCAN: begin
        if (sts.fires_max) state_nxt = stt_pkg::ST_LAST;
        else if (sts.hit) state_nxt = stt_pkg::ST_FIRE;
        else if (sts.scan_end) state_nxt = sts.held ? stt_pkg::ST_LAST : stt_pkg::ST_IDLE;
      end
      stt_pkg::ST_FIRE: if (!sts.out_full) state_nxt = stt_pkg::ST_OUT;
      stt_pkg::ST_OUT: state_nxt = stt_pkg::ST_SCAN;
      stt_pkg::ST_LAST: if (!sts.out_full) state_nxt = stt_pkg::ST_IDLE;
      stt_pkg::ST_OP: if (!sts.out_full) state_nxt = stt_pkg::ST_IDLE;
      default: state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cmd.out_pop = out_ready;
    case (state_r)
      stt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      stt_pkg::ST_TIME: begin
        cmd.adv_time = sts.is_tick;
        cmd.scan_clr = 1'b1;
      end
      stt_pkg::ST_SCAN: cmd.scan_step = !sts.fires_max && !sts.hit;
      stt_pkg::ST_FIRE: cmd.fire = !sts.out_full;
      stt_pkg::ST_OUT: cmd.scan_clr = 1'b1;
      stt_pkg::ST_LAST: cmd.emit_last = !sts.out_full;
      stt_pkg::ST_OP: cmd.do_op = !sts.out_full;
      default: ;
    endcase
  end
endmodule

[hdl/stt_dpath.sv]
// Datapath: slot table, clock, scan pointer and result register.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_dpath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              in_mode,
  input  logic [15:0]             in_line_count,
  input  logic [3:0]              in_slot,
  input  logic [31:0]             in_time_value,
  input  logic                    in_restart,
  input  logic                    cfg_valid,
  input  logic [7:0]              cfg_us_per_line,
  input  stt_pkg::stt_cmd_t       cmd,
  output stt_pkg::stt_sts_t       sts,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [3:0]              out_slot_out,
  output logic [31:0]             out_fire_time,
  output logic                    out_last
);
  logic [stt_pkg::NumTimers-1:0] used_r, periodic_r, paused_r;
  logic [31:0] deadline_r [stt_pkg::NumTimers];
  logic [31:0] period_r [stt_pkg::NumTimers];
  logic [31:0] remain_r [stt_pkg::NumTimers];
  logic [31:0] now_r;
  logic [15:0] prev_r;
  logic [7:0]  upl_r;
  logic [2:0]  mode_r;
  logic [15:0] line_r;
  logic [stt_pkg::SlotW-1:0] slot_r, ptr_r;
  logic [31:0] tv_r;
  logic        restart_r;
  logic [stt_pkg::FireCntW-1:0] fires_r;
  logic [31:0] dl_diff;
  logic [15:0] ldiff;
  logic [stt_pkg::SlotW-1:0] free_idx;
  logic        free_any;
  logic        held_r; // a fire beat still owes its last flag
  logic [stt_pkg::SlotW-1:0] hold_slot_r;

  assign ldiff = line_r - prev_r;
  assign dl_diff = deadline_r[ptr_r] - now_r;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = stt_pkg::NumTimers - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = stt_pkg::SlotW'(i);
      end
    end
  end

  assign sts.is_tick = mode_r == stt_pkg::MODE_TICK;
  assign sts.is_none = mode_r == stt_pkg::MODE_NONE;
  assign sts.hit = used_r[ptr_r] && !paused_r[ptr_r] && (dl_diff == '0 || dl_diff[31]);
  assign sts.scan_end = ptr_r == stt_pkg::SlotW'(stt_pkg::NumTimers - 1);
  assign sts.fires_max = fires_r == stt_pkg::FireCntW'(stt_pkg::MaxFires);
  assign sts.held = held_r;
  assign sts.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      now_r <= '0;
      prev_r <= '0;
      upl_r <= 8'd64;
      out_valid <= 1'b0;
      held_r <= 1'b0;
      mode_r <= stt_pkg::MODE_NONE;
    end else begin
      if (cfg_valid) upl_r <= cfg_us_per_line;
      if (out_valid && cmd.out_pop) out_valid <= 1'b0;
      if (cmd.load) begin
        mode_r <= in_mode; line_r <= in_line_count; slot_r <= in_slot;
        tv_r <= in_time_value; restart_r <= in_restart;
        fires_r <= '0;
      end
      if (cmd.adv_time) begin
        now_r <= now_r + 32'(ldiff) * 32'(upl_r);
        prev_r <= line_r;
      end
      if (cmd.scan_clr) ptr_r <= '0;
      else if (cmd.scan_step) ptr_r <= ptr_r + 1'b1;
      // another firing follows the held one, so the held one is not last
      if (cmd.fire) begin
        if (held_r) begin
          out_valid <= 1'b1; out_last <= 1'b0;
          out_kind <= stt_pkg::KIND_FIRED; out_slot_out <= hold_slot_r; out_fire_time <= now_r;
        end
        held_r <= 1'b1;
        hold_slot_r <= ptr_r;
        if (periodic_r[ptr_r]) deadline_r[ptr_r] <= deadline_r[ptr_r] + period_r[ptr_r];
        else used_r[ptr_r] <= 1'b0;
        fires_r <= fires_r + 1'b1;
      end
      if (cmd.emit_last) begin
        held_r <= 1'b0;
        out_valid <= 1'b1; out_last <= 1'b1;
        out_kind <= stt_pkg::KIND_FIRED; out_slot_out <= hold_slot_r; out_fire_time <= now_r;
      end
      if (cmd.do_op) begin
        out_valid <= 1'b1; out_last <= 1'b1;
        out_kind <= stt_pkg::KIND_DONE; out_slot_out <= '0; out_fire_time <= '0;
        case (mode_r)
          stt_pkg::MODE_ARM_ONE, stt_pkg::MODE_ARM_PER: begin
            if (free_any) begin
              used_r[free_idx] <= 1'b1;
              periodic_r[free_idx] <= mode_r == stt_pkg::MODE_ARM_PER;
              paused_r[free_idx] <= 1'b0;
              remain_r[free_idx] <= '0;
              period_r[free_idx] <= (mode_r == stt_pkg::MODE_ARM_PER) ? tv_r : '0;
              deadline_r[free_idx] <= (mode_r == stt_pkg::MODE_ARM_PER) ? now_r + tv_r : tv_r;
              out_kind <= stt_pkg::KIND_ARMED; out_slot_out <= free_idx;
            end else out_kind <= stt_pkg::KIND_FULL;
          end
          stt_pkg::MODE_CHANGE:
            if (used_r[slot_r] && periodic_r[slot_r] && period_r[slot_r] != tv_r) begin
              deadline_r[slot_r] <= restart_r ? now_r + tv_r
                                    : deadline_r[slot_r] + (tv_r - period_r[slot_r]);
              period_r[slot_r] <= tv_r;
            end
          stt_pkg::MODE_PAUSE:
            if (used_r[slot_r] && !paused_r[slot_r]) begin
              paused_r[slot_r] <= 1'b1;
              remain_r[slot_r] <= deadline_r[slot_r] - now_r;
            end
          stt_pkg::MODE_RESUME:
            if (used_r[slot_r] && paused_r[slot_r]) begin
              paused_r[slot_r] <= 1'b0;
              deadline_r[slot_r] <= now_r + remain_r[slot_r];
            end
          stt_pkg::MODE_CANCEL: if (used_r[slot_r]) used_r[slot_r] <= 1'b0;
          default: ;
        endcase
      end
    end
  end
endmodule

[hdl/software_timer_table.sv]
// Top level of the software timer table: controller plus datapath.
// Depends on stt_pkg, stt_ctrl, stt_dpath.
//
//  channel | ports                                           | dir
//  in      | in_valid/ready, mode, line_count, slot, time_value, restart | in
//  out     | out_valid/ready, kind, slot_out, fire_time, last | out
//  cfg     | cfg_valid/ready, cfg_us_per_line                  | in
//
// Requests pass accept, decode and a registered reply. On a tick, a scan pass
// examines the 16 slots, one slot per cycle while none is due; each firing passes
// the fire and out steps and restarts the pass from slot 0. A fire beat waits in a
// hold register until the next firing sends it with last clear, or the scan end or
// fire budget sends it with last set. Reset: synchronous, clears slot use marks,
// clock, line count, us_per_line to 64. Output stalls hold the fire and reply steps.
`timescale 1ns / 1ps
module software_timer_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_line_count,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_time_value,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_fire_time,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_us_per_line
);
  stt_pkg::stt_cmd_t cmd;
  stt_pkg::stt_sts_t sts;

  assign cfg_ready = 1'b1;

  stt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .sts, .cmd
  );

  stt_dpath u_dpath (
    .clk, .rst_n, .in_mode, .in_line_count, .in_slot, .in_time_value, .in_restart,
    .cfg_valid, .cfg_us_per_line, .cmd, .sts, .out_valid, .out_kind, .out_slot_out,
    .out_fire_time, .out_last
  );
endmodule
